FILE: rtl/particle_boundary_condition_unit_defines.svh
// -----------------------------------------------------------------------------
// particle boundary condition unit: assertion macros
// Shared concurrent assertion forms, sampled on clock and quiet during reset.
// -----------------------------------------------------------------------------
`ifndef PARTICLE_BOUNDARY_CONDITION_UNIT_DEFINES_SVH
`define PARTICLE_BOUNDARY_CONDITION_UNIT_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define PBCU_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define PBCU_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pbcu_pkg.sv
// -----------------------------------------------------------------------------
// pbcu_pkg
// Types, widths and codes shared by the boundary condition unit.
// -----------------------------------------------------------------------------
package pbcu_pkg;

   // number formats
   localparam int DIMS       = 3;
   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int DIM_W      = 2;
   localparam int NUM_BOUNDS = 3;
   localparam int SUM_W      = 48;

   // derived arithmetic widths
   localparam int PROD_W     = 2 * DATA_W;
   localparam int SCALED_W   = PROD_W - FRAC_BITS;
   localparam int FORCE_W    = SCALED_W + 4;
   localparam int SQ_W       = SCALED_W;
   localparam int SQ_HI_W    = SQ_W - DATA_W;
   localparam int EHI_W      = DATA_W + SQ_HI_W;
   localparam int ECARRY_W   = EHI_W + 1;
   localparam int ENERGY_W   = PROD_W - FRAC_BITS - 1;
   localparam int FSUM_ADD_W = ((FORCE_W > SUM_W) ? FORCE_W : SUM_W) + 1;
   localparam int ESUM_ADD_W = ((ENERGY_W > SUM_W) ? ENERGY_W : SUM_W) + 1;

   // saturation limits
   localparam logic [DATA_W-1:0] POS_LIMIT = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] NEG_LIMIT = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [SUM_W-1:0]  FSUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]  ESUM_MAX  = {SUM_W{1'b1}};

   // sequencer steps
   localparam int DIV_STEPS = DATA_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] STEP_SPRING   = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_DAMP     = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_SQUARE   = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEP_SQ_TAKE  = STEP_W'(3);
   localparam logic [STEP_W-1:0] STEP_E_LO     = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_E_HI     = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_ENERGY   = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEP_DIV_LAST = STEP_W'(DIV_STEPS - 1);

   // work queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register file
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_LSB    = 3;
   localparam int REG_IDX_W  = CSR_ADDR_W - REG_LSB;
   localparam int BC_MODES_W = 2 * NUM_BOUNDS;
   localparam logic [BC_MODES_W-1:0] BC_MODES_RESET = BC_MODES_W'(21);

   localparam logic [REG_IDX_W-1:0] REG_BC_MODES    = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_BOUNDS0     = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_BOUNDS1     = REG_IDX_W'(2);
   localparam logic [REG_IDX_W-1:0] REG_BOUNDS2     = REG_IDX_W'(3);
   localparam logic [REG_IDX_W-1:0] REG_REPULSION   = REG_IDX_W'(4);
   localparam logic [REG_IDX_W-1:0] REG_DISSIPATION = REG_IDX_W'(5);

   typedef enum logic [1:0] {
      MODE_OPEN    = 2'd0,
      MODE_WRAP    = 2'd1,
      MODE_REFLECT = 2'd2,
      MODE_REPEL   = 2'd3
   } bc_mode_type;

   typedef enum logic [1:0] {
      OP_PASS  = 2'd0,
      OP_WRAP  = 2'd1,
      OP_REPEL = 2'd2
   } op_type;

   typedef struct packed {
      logic [DIM_W-1:0]         dimension;
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] velocity;
      logic                     pass_start;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] new_position;
      logic signed [DATA_W-1:0] new_velocity;
      logic signed [DATA_W-1:0] force_delta;
      logic signed [SUM_W-1:0]  wall_force_sum;
      logic [SUM_W-1:0]         wall_energy_sum;
   } rsp_type;

   typedef struct packed {
      logic [BC_MODES_W-1:0]                    bc_modes;
      logic [NUM_BOUNDS-1:0][CSR_DATA_W-1:0]    bounds;
      logic [DATA_W-1:0]                        repulsion_gain;
      logic [DATA_W-1:0]                        dissipation_gain;
   } config_type;

   // classified item: opa is dividend or overshoot, opb divisor or speed
   typedef struct packed {
      op_type            op;
      logic              pass_start;
      logic              below;
      logic [DATA_W-1:0] position;
      logic [DATA_W-1:0] velocity;
      logic [DATA_W-1:0] opa;
      logic [DATA_W-1:0] opb;
   } work_type;

   typedef struct packed {
      logic     not_empty;
      work_type work;
   } queue_head_type;

endpackage

FILE: rtl/pbcu_csr.sv
// -----------------------------------------------------------------------------
// pbcu_csr
// Configuration register file behind the APB-style port.
// -----------------------------------------------------------------------------
module pbcu_csr import pbcu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output config_type            cfg
);

   config_type             cfg_ff;
   config_type             cfg_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:REG_LSB];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_BC_MODES:    cfg_in.bc_modes         = pwdata[BC_MODES_W-1:0];
            REG_BOUNDS0:     cfg_in.bounds[0]        = pwdata;
            REG_BOUNDS1:     cfg_in.bounds[1]        = pwdata;
            REG_BOUNDS2:     cfg_in.bounds[2]        = pwdata;
            REG_REPULSION:   cfg_in.repulsion_gain   = pwdata[DATA_W-1:0];
            REG_DISSIPATION: cfg_in.dissipation_gain = pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_BC_MODES:    prdata = CSR_DATA_W'(cfg_ff.bc_modes);
         REG_BOUNDS0:     prdata = cfg_ff.bounds[0];
         REG_BOUNDS1:     prdata = cfg_ff.bounds[1];
         REG_BOUNDS2:     prdata = cfg_ff.bounds[2];
         REG_REPULSION:   prdata = CSR_DATA_W'(cfg_ff.repulsion_gain);
         REG_DISSIPATION: prdata = CSR_DATA_W'(cfg_ff.dissipation_gain);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bc_modes         <= BC_MODES_RESET;
         cfg_ff.bounds           <= '0;
         cfg_ff.repulsion_gain   <= '0;
         cfg_ff.dissipation_gain <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/pbcu_front.sv
// -----------------------------------------------------------------------------
// pbcu_front
// Accepts request transfers, looks up the dimension's mode and bounds and
// sorts each item into pass-through, wrap or repel work. Reflection is
// finished here since it is one add and a clamp.
// -----------------------------------------------------------------------------
module pbcu_front import pbcu_pkg::*; (
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  config_type cfg,
   input  logic       queue_full,
   output logic       push,
   output work_type   work
);

   bc_mode_type              mode;
   logic signed [DATA_W-1:0] lo;
   logic signed [DATA_W-1:0] hi;
   logic signed [DATA_W-1:0] x;
   logic signed [DATA_W-1:0] v;
   logic signed [DATA_W:0]   x_ext;
   logic signed [DATA_W:0]   lo_ext;
   logic signed [DATA_W:0]   hi_ext;
   logic signed [DATA_W:0]   span;
   logic signed [DATA_W:0]   lo_minus_x;
   logic signed [DATA_W:0]   x_minus_lo;
   logic signed [DATA_W:0]   x_minus_hi;
   logic signed [DATA_W+1:0] mirror_lo;
   logic signed [DATA_W+1:0] mirror_hi;
   logic signed [DATA_W-1:0] v_neg;
   logic                     below;
   logic                     at_or_above;
   logic                     above;
   logic                     span_pos;

   function automatic logic [DATA_W-1:0] sat_data(input logic signed [DATA_W+1:0] val);
      logic signed [DATA_W+1:0] max_ext;
      logic signed [DATA_W+1:0] min_ext;
      max_ext = $signed({2'b00, POS_LIMIT});
      min_ext = $signed({2'b11, NEG_LIMIT});
      if (val > max_ext) begin
         return POS_LIMIT;
      end else if (val < min_ext) begin
         return NEG_LIMIT;
      end
      return val[DATA_W-1:0];
   endfunction

   // handshake into the work queue
   assign req_ready = !queue_full;
   assign push      = req_valid & req_ready;

   // mode and bounds of the addressed dimension, open when out of range
   always_comb begin
      mode = MODE_OPEN;
      lo   = '0;
      hi   = '0;
      for (int d = 0; d < NUM_BOUNDS; d++) begin
         if (d < DIMS && req_data.dimension == DIM_W'(d)) begin
            mode = bc_mode_type'(cfg.bc_modes[2*d +: 2]);
            lo   = cfg.bounds[d][CSR_DATA_W-1:DATA_W];
            hi   = cfg.bounds[d][DATA_W-1:0];
         end
      end
   end

   // comparisons and differences
   assign x           = req_data.position;
   assign v           = req_data.velocity;
   assign x_ext       = {x[DATA_W-1], x};
   assign lo_ext      = {lo[DATA_W-1], lo};
   assign hi_ext      = {hi[DATA_W-1], hi};
   assign span        = hi_ext - lo_ext;
   assign span_pos    = !span[DATA_W] && (span != '0);
   assign lo_minus_x  = lo_ext - x_ext;
   assign x_minus_lo  = x_ext - lo_ext;
   assign x_minus_hi  = x_ext - hi_ext;
   assign below       = x < lo;
   assign at_or_above = x >= hi;
   assign above       = x > hi;

   // mirrored positions and negated velocity
   assign mirror_lo = {lo_ext, 1'b0} - {{2{x[DATA_W-1]}}, x};
   assign mirror_hi = {hi_ext, 1'b0} - {{2{x[DATA_W-1]}}, x};
   assign v_neg     = (v == $signed(NEG_LIMIT)) ? $signed(POS_LIMIT) : -v;

   // classify
   always_comb begin
      work.op         = OP_PASS;
      work.pass_start = req_data.pass_start;
      work.below      = 1'b0;
      work.position   = x;
      work.velocity   = v;
      work.opa        = '0;
      work.opb        = '0;
      case (mode)
         MODE_OPEN: ;
         MODE_WRAP: begin
            if (span_pos && below) begin
               work.op       = OP_WRAP;
               work.below    = 1'b1;
               work.opa      = lo_minus_x[DATA_W-1:0];
               work.opb      = span[DATA_W-1:0];
               work.position = hi;
            end else if (span_pos && at_or_above) begin
               work.op       = OP_WRAP;
               work.opa      = x_minus_lo[DATA_W-1:0];
               work.opb      = span[DATA_W-1:0];
               work.position = lo;
            end
         end
         MODE_REFLECT: begin
            if (below) begin
               work.position = sat_data(mirror_lo);
               work.velocity = v_neg;
            end else if (above) begin
               work.position = sat_data(mirror_hi);
               work.velocity = v_neg;
            end
         end
         MODE_REPEL: begin
            // outward speed clamped at zero
            if (below) begin
               work.op    = OP_REPEL;
               work.below = 1'b1;
               work.opa   = lo_minus_x[DATA_W-1:0];
               work.opb   = v[DATA_W-1] ? (DATA_W'(0) - v) : '0;
            end else if (above) begin
               work.op  = OP_REPEL;
               work.opa = x_minus_hi[DATA_W-1:0];
               work.opb = v[DATA_W-1] ? '0 : v;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/pbcu_queue.sv
// -----------------------------------------------------------------------------
// pbcu_queue
// Short work queue that decouples classification from execution.
// -----------------------------------------------------------------------------
`include "particle_boundary_condition_unit_defines.svh"

module pbcu_queue import pbcu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  work_type       push_work,
   input  logic           pop,
   output logic           full,
   output queue_head_type head
);

   work_type            entries_ff [QUEUE_DEPTH];
   work_type            entries_in [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
      return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
   endfunction

   assign full           = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.not_empty = (count_ff != '0);
   assign head.work      = entries_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_work;
         wr_ptr_in             = ptr_next(wr_ptr_ff);
      end
      if (pop) begin
         rd_ptr_in = ptr_next(rd_ptr_ff);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   // checks
   `PBCU_ASSERT_IMPLY(a_pop_not_empty, pop, count_ff != '0, "pop from an empty work queue")
   `PBCU_ASSERT_IMPLY(a_count_bound, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
   `PBCU_ASSERT_NEXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + QCNT_W'(1), "push lost")

endmodule

FILE: rtl/pbcu_back.sv
// -----------------------------------------------------------------------------
// pbcu_back
// Executes queued work: a restoring remainder divider for wrap, a shared
// 32x32 multiplier sequence for the repel force and energy, the saturating
// running sums and the response output register.
// -----------------------------------------------------------------------------
`include "particle_boundary_condition_unit_defines.svh"

module pbcu_back import pbcu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  config_type     cfg,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_WFIX = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [STEP_W-1:0]       count_ff, count_in;
   op_type                  op_ff, op_in;
   logic                    below_ff, below_in;
   logic                    pass_start_ff, pass_start_in;
   logic [DATA_W-1:0]       pos_ff, pos_in;
   logic [DATA_W-1:0]       vel_ff, vel_in;
   logic [DATA_W-1:0]       opa_ff, opa_in;
   logic [DATA_W-1:0]       opb_ff, opb_in;
   logic [DATA_W:0]         rem_ff, rem_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [FORCE_W-1:0]      spring_ff, spring_in;
   logic [FORCE_W-1:0]      force_ff, force_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic [PROD_W-1:0]       elo_ff, elo_in;
   logic [ENERGY_W-1:0]     energy_ff, energy_in;
   logic                    e_ovf_ff, e_ovf_in;
   logic [SUM_W-1:0]        facc_ff, facc_in;
   logic [SUM_W-1:0]        eacc_ff, eacc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [DATA_W-1:0]       mul_a;
   logic [DATA_W-1:0]       mul_b;
   logic [DATA_W:0]         rem_shift;
   logic [DATA_W:0]         rem_next;
   logic [DATA_W-1:0]       remainder;
   logic [DATA_W-1:0]       wrap_pos;
   logic [SCALED_W-1:0]     scaled;
   logic [ECARRY_W-1:0]     carry_sum;
   logic [PROD_W-1:0]       energy_prod;
   logic [SUM_W-1:0]        fsum_base;
   logic [SUM_W-1:0]        esum_base;
   logic [FSUM_ADD_W-1:0]   fsum_wide;
   logic [ESUM_ADD_W-1:0]   esum_wide;
   logic [SUM_W-1:0]        fsum_sat;
   logic [SUM_W-1:0]        esum_sat;
   logic [DATA_W-1:0]       fd_below;
   logic [DATA_W-1:0]       fd_above;
   logic [DATA_W-1:0]       force_delta;
   logic                    commit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // multiplier operand select per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (count_ff)
         STEP_SPRING: begin
            mul_a = cfg.repulsion_gain;
            mul_b = opa_ff;
         end
         STEP_DAMP: begin
            mul_a = cfg.dissipation_gain;
            mul_b = opb_ff;
         end
         STEP_SQUARE: begin
            mul_a = opa_ff;
            mul_b = opa_ff;
         end
         STEP_E_LO: begin
            mul_a = cfg.repulsion_gain;
            mul_b = sq_ff[DATA_W-1:0];
         end
         STEP_E_HI: begin
            mul_a = cfg.repulsion_gain;
            mul_b = DATA_W'(sq_ff[SQ_W-1:DATA_W]);
         end
         default: ;
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign scaled  = prod_ff[PROD_W-1:FRAC_BITS];

   // one restoring remainder step
   assign rem_shift = {rem_ff[DATA_W-1:0], opa_ff[DATA_W-1]};
   assign rem_next  = (rem_shift >= {1'b0, opb_ff}) ? (rem_shift - {1'b0, opb_ff}) : rem_shift;

   // wrapped position from the remainder: pos_ff holds the base bound
   assign remainder = rem_ff[DATA_W-1:0];
   always_comb begin
      if (!below_ff) begin
         wrap_pos = pos_ff + remainder;
      end else if (remainder == '0) begin
         wrap_pos = pos_ff - opb_ff;
      end else begin
         wrap_pos = pos_ff - remainder;
      end
   end

   // energy product: low partial plus high partial shifted by a word
   assign carry_sum   = ECARRY_W'(prod_ff[EHI_W-1:0]) + ECARRY_W'(elo_ff[PROD_W-1:DATA_W]);
   assign energy_prod = {carry_sum[DATA_W-1:0], elo_ff[DATA_W-1:0]};

   // saturating running sums
   assign fsum_base = pass_start_ff ? '0 : facc_ff;
   assign esum_base = pass_start_ff ? '0 : eacc_ff;
   assign fsum_wide = FSUM_ADD_W'(fsum_base) + FSUM_ADD_W'(force_ff);
   assign esum_wide = ESUM_ADD_W'(esum_base) + ESUM_ADD_W'(energy_ff);
   assign fsum_sat  = (fsum_wide > FSUM_ADD_W'(FSUM_MAX)) ? FSUM_MAX : fsum_wide[SUM_W-1:0];
   assign esum_sat  = (e_ovf_ff || esum_wide > ESUM_ADD_W'(ESUM_MAX)) ?
                      ESUM_MAX : esum_wide[SUM_W-1:0];

   // force on the particle, pushing back inside
   assign fd_below = (force_ff > FORCE_W'(POS_LIMIT)) ? POS_LIMIT : force_ff[DATA_W-1:0];
   assign fd_above = (force_ff > FORCE_W'(NEG_LIMIT)) ? NEG_LIMIT :
                     (DATA_W'(0) - force_ff[DATA_W-1:0]);
   assign force_delta = (op_ff != OP_REPEL) ? '0 : (below_ff ? fd_below : fd_above);

   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      below_in      = below_ff;
      pass_start_in = pass_start_ff;
      pos_in        = pos_ff;
      vel_in        = vel_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      rem_in        = rem_ff;
      spring_in     = spring_ff;
      force_in      = force_ff;
      sq_in         = sq_ff;
      elo_in        = elo_ff;
      energy_in     = energy_ff;
      e_ovf_in      = e_ovf_ff;
      facc_in       = facc_ff;
      eacc_in       = eacc_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.not_empty) begin
               pop           = 1'b1;
               op_in         = head.work.op;
               below_in      = head.work.below;
               pass_start_in = head.work.pass_start;
               pos_in        = head.work.position;
               vel_in        = head.work.velocity;
               opa_in        = head.work.opa;
               opb_in        = head.work.opb;
               rem_in        = '0;
               count_in      = '0;
               case (head.work.op)
                  OP_WRAP:  state_in = ST_DIV;
                  OP_REPEL: state_in = ST_MUL;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_DIV: begin
            rem_in   = rem_next;
            opa_in   = opa_ff << 1;
            count_in = count_ff + STEP_W'(1);
            if (count_ff == STEP_DIV_LAST) begin
               state_in = ST_WFIX;
            end
         end
         ST_WFIX: begin
            pos_in   = wrap_pos;
            state_in = ST_DONE;
         end
         ST_MUL: begin
            count_in = count_ff + STEP_W'(1);
            case (count_ff)
               STEP_DAMP:    spring_in = (FORCE_W'(scaled) << 3) + (FORCE_W'(scaled) << 1);
               STEP_SQUARE:  force_in  = spring_ff + FORCE_W'(scaled);
               STEP_SQ_TAKE: sq_in     = scaled;
               STEP_E_HI:    elo_in    = prod_ff;
               STEP_ENERGY: begin
                  energy_in = energy_prod[PROD_W-1:FRAC_BITS+1];
                  e_ovf_in  = |carry_sum[ECARRY_W-1:DATA_W];
                  state_in  = ST_DONE;
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (commit) begin
               facc_in                     = (op_ff == OP_REPEL) ? fsum_sat : fsum_base;
               eacc_in                     = (op_ff == OP_REPEL) ? esum_sat : esum_base;
               rsp_valid_in                = 1'b1;
               rsp_data_in.new_position    = pos_ff;
               rsp_data_in.new_velocity    = vel_ff;
               rsp_data_in.force_delta     = force_delta;
               rsp_data_in.wall_force_sum  = facc_in;
               rsp_data_in.wall_energy_sum = eacc_in;
               state_in                    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         facc_ff      <= '0;
         eacc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         facc_ff      <= facc_in;
         eacc_ff      <= eacc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      below_ff      <= below_in;
      pass_start_ff <= pass_start_in;
      pos_ff        <= pos_in;
      vel_ff        <= vel_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      rem_ff        <= rem_in;
      prod_ff       <= prod_in;
      spring_ff     <= spring_in;
      force_ff      <= force_in;
      sq_ff         <= sq_in;
      elo_ff        <= elo_in;
      energy_ff     <= energy_in;
      e_ovf_ff      <= e_ovf_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // checks
   `PBCU_ASSERT_IMPLY(a_div_nonzero, state_ff == ST_DIV, opb_ff != '0, "wrap with empty span")
   `PBCU_ASSERT_IMPLY(a_fsum_range, 1'b1, !facc_ff[SUM_W-1], "force sum above its maximum")
   `PBCU_ASSERT_NEXT(a_commit, commit, rsp_valid_ff && state_ff == ST_IDLE, "result not issued")

endmodule

FILE: rtl/particle_boundary_condition_unit.sv
// -----------------------------------------------------------------------------
// particle_boundary_condition_unit
// Open, reflect: finished in the front; the back end takes one item at a time.
// Repel: seven steps of the shared multiplier for force and energy.
// Wrap: the 32-step remainder divider; the queue takes requests meanwhile.
// Synchronous reset clears sums, queue and handshakes; registers take defaults.
// -----------------------------------------------------------------------------
module particle_boundary_condition_unit import pbcu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   config_type     cfg;
   logic           queue_full;
   logic           push;
   work_type       push_work;
   logic           pop;
   queue_head_type head;

   // configuration registers
   pbcu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // classification
   pbcu_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .work       (push_work)
   );

   // work queue
   pbcu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_work (push_work),
      .pop       (pop),
      .full      (queue_full),
      .head      (head)
   );

   // execution and result register
   pbcu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
